@@ rtl/core/gda_pkg.sv @@
package gda_pkg;

  // default widths
  localparam int STEP_BITS_DEF = 8;
  localparam int YEAR_BITS_DEF = 16;

  // step register value after reset
  localparam int STEP_RESET = 5;

  // calendar constants
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_JUL = 4'd7;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [4:0] DAYS_LONG   = 5'd31;
  localparam logic [4:0] DAYS_SHORT  = 5'd30;
  localparam logic [4:0] DAYS_FEB_LP = 5'd29;
  localparam logic [4:0] DAYS_FEB    = 5'd28;
  localparam logic [4:0] DAYS_NONE   = 5'd0;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input word into the date registers
    logic check;     // latch the validity flag and load the day counter
    logic step;      // advance the date by one day
    logic load_out;  // move the date into the output register
  } gda_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic date_ok;
    logic cnt_zero;
  } gda_sts_t;

  // length of a month, zero for a month code that is out of range
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = DAYS_LONG;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:                           len = DAYS_SHORT;
      MON_FEB: len = leap ? DAYS_FEB_LP : DAYS_FEB;
      default: len = DAYS_NONE;
    endcase
    return len;
  endfunction

  // inverse of 25 modulo 2^64 by Newton iteration, for elaboration only
  function automatic logic [63:0] inv25();
    logic [63:0] x;
    x = 64'd25;
    for (int i = 0; i < 5; i++) begin
      x = x * (64'd2 - 64'd25 * x);
    end
    return x;
  endfunction

endpackage

@@ rtl/core/gregorian_date_advance.sv @@
// Gregorian date advance: check a date, then step it forward step_days days.
// The word is captured, the leap flag prepared, the date checked and the day counter
// loaded, then the day-step loop advances one day per cycle and the output register loads;
// a rejected date skips the loop. No new word is taken until the result is loaded, and
// a stalled output holds the finished date in FINISH until the output register is free.
// Reset (rst, synchronous): control idle, output empty, step_days back to 5.
module gregorian_date_advance #(
  parameter int STEP_BITS = gda_pkg::STEP_BITS_DEF,
  parameter int YEAR_BITS = gda_pkg::YEAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [4:0]           day,
  input  logic [3:0]           month,
  input  logic [YEAR_BITS-1:0] year,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 valid_res,
  output logic [4:0]           out_day,
  output logic [3:0]           out_month,
  output logic [YEAR_BITS-1:0] out_year
);

  gda_pkg::gda_cmd_t cmd;
  gda_pkg::gda_sts_t sts;

  // sequencer
  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // date registers, day stepper and output register
  gda_dpath #(
    .STEP_BITS (STEP_BITS),
    .YEAR_BITS (YEAR_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .day       (day),
    .month     (month),
    .year      (year),
    .cmd       (cmd),
    .sts       (sts),
    .valid_res (valid_res),
    .out_day   (out_day),
    .out_month (out_month),
    .out_year  (out_year)
  );

endmodule

@@ rtl/core/gda_ctrl.sv @@
module gda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  gda_pkg::gda_sts_t sts,
  output gda_pkg::gda_cmd_t cmd
);

  typedef enum logic [2:0] {
    IDLE,
    PREP,
    CHECK,
    STEP,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE);

  // decode commands from the state
  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == IDLE) && in_valid;
    cmd.check    = (state == CHECK);
    cmd.step     = (state == STEP) && !sts.cnt_zero;
    cmd.load_out = (((state == STEP) && sts.cnt_zero) || (state == FINISH)) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      IDLE:    if (in_valid) state_next = PREP;
      PREP:    state_next = CHECK;
      CHECK:   state_next = sts.date_ok ? STEP : FINISH;
      STEP: begin
        if (sts.cnt_zero) state_next = out_free ? IDLE : FINISH;
      end
      FINISH:  if (out_free) state_next = IDLE;
      default: state_next = IDLE;
    endcase
  end

  // hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // an accepted word always starts the leap preparation cycle
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == PREP))
    else $error("accepted word did not start processing");

  // a fresh result only appears from the end of stepping or the wait state
  a_rose_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == STEP || $past(state) == FINISH))
    else $error("result raised from an unexpected state");

  // a finished date with the output blocked waits in FINISH
  a_wait_out: assert property (@(posedge clk) disable iff (rst)
    (state == STEP && sts.cnt_zero && out_valid && out_stall) |=> (state == FINISH))
    else $error("finished date dropped while output busy");

endmodule

@@ rtl/core/gda_dpath.sv @@
module gda_dpath #(
  parameter int STEP_BITS = gda_pkg::STEP_BITS_DEF,
  parameter int YEAR_BITS = gda_pkg::YEAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [STEP_BITS-1:0] cfg_wdata,
  input  logic [4:0]           day,
  input  logic [3:0]           month,
  input  logic [YEAR_BITS-1:0] year,
  input  gda_pkg::gda_cmd_t    cmd,
  output gda_pkg::gda_sts_t    sts,
  output logic                 valid_res,
  output logic [4:0]           out_day,
  output logic [3:0]           out_month,
  output logic [YEAR_BITS-1:0] out_year
);

  localparam logic [63:0]          YEAR_MAX = (64'd1 << YEAR_BITS) - 64'd1;
  localparam logic [YEAR_BITS-1:0] INV25    = YEAR_BITS'(gda_pkg::inv25());
  localparam logic [YEAR_BITS-1:0] LIM25    = YEAR_BITS'(YEAR_MAX / 64'd25);

  logic [STEP_BITS-1:0] step_days;
  logic [STEP_BITS-1:0] count;
  logic [4:0]           cur_day;
  logic [3:0]           cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic                 leap;
  logic                 date_ok;

  logic [YEAR_BITS-1:0] prod25;
  logic                 div25;
  logic                 leap_next;
  logic [4:0]           len;
  logic                 ok_now;

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_days <= STEP_BITS'(gda_pkg::STEP_RESET);
    end else if (cfg_we) begin
      step_days <= cfg_wdata;
    end
  end

  // leap flag: divisible by 25 test by modular inverse, registered from the year
  assign prod25    = cur_year * INV25;
  assign div25     = (prod25 <= LIM25);
  assign leap_next = (cur_year[1:0] == 2'd0) && (!div25 || (cur_year[3:0] == 4'd0));

  always_ff @(posedge clk) begin
    leap <= leap_next;
  end

  // range check of the current date
  assign len    = gda_pkg::month_len(cur_month, leap);
  assign ok_now = (len != gda_pkg::DAYS_NONE) && (cur_day != 5'd0) && (cur_day <= len);

  assign sts.date_ok  = ok_now;
  assign sts.cnt_zero = (count == '0);

  // date registers: capture, then advance one day per step
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_day   <= day;
      cur_month <= month;
      cur_year  <= year;
    end else if (cmd.step) begin
      if (cur_day >= len) begin
        cur_day <= 5'd1;
        if (cur_month >= gda_pkg::MON_DEC) begin
          cur_month <= gda_pkg::MON_JAN;
          cur_year  <= cur_year + YEAR_BITS'(1);
        end else begin
          cur_month <= cur_month + 4'd1;
        end
      end else begin
        cur_day <= cur_day + 5'd1;
      end
    end
  end

  // day counter and validity flag
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      count   <= step_days;
      date_ok <= ok_now;
    end else if (cmd.step) begin
      count <= count - STEP_BITS'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      valid_res <= date_ok;
      out_day   <= cur_day;
      out_month <= cur_month;
      out_year  <= cur_year;
    end
  end

  // stepping only ever runs on a date in range
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (cur_month >= gda_pkg::MON_JAN && cur_month <= gda_pkg::MON_DEC &&
                  cur_day != 5'd0 && cur_day <= len))
    else $error("stepping a date out of range");

endmodule

@@ tb/gregorian_date_advance_tb.sv @@
module gregorian_date_advance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT       = 2_000_000;
  localparam int N_PHASES    = 8;
  localparam int HOLD_PHASE  = 1;
  localparam int QUIET_PHASE = 7;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [4:0]  d;
    logic [3:0]  m;
    logic [15:0] y;
  } date_t;

  typedef struct packed {
    logic  ok;
    date_t dt;
  } next_date_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  day = '0;
  logic [3:0]  month = '0;
  logic [15:0] year = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [15:0] out_year;

  date_t      start_dates[$];
  next_date_t due_results[$];
  logic [7:0] step_now = 8'(gda_pkg::STEP_RESET);
  logic       quiet = 1'b0;
  logic       rx_hold_arm = 1'b0;
  logic       hold_taken = 1'b0;
  int         hold_left = 0;
  int         fails = 0;
  int         n_valid = 0;
  int         n_invalid = 0;
  int         cycles = 0;

  logic [7:0] step_list[N_PHASES] = '{8'd0, 8'd1, 8'd5, 8'd31, 8'd60, 8'd255, 8'd128, 8'd2};
  int count_list[N_PHASES] = '{150, 250, 250, 200, 150, 40, 60, 250};

  gregorian_date_advance u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .day       (day),
    .month     (month),
    .year      (year),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .out_day   (out_day),
    .out_month (out_month),
    .out_year  (out_year)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // leap rule: every fourth year, but centuries only when divisible by 400
  function automatic logic leap_year(logic [15:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] m, logic [15:0] y);
    case (m)
      gda_pkg::MON_JAN, gda_pkg::MON_MAR, gda_pkg::MON_MAY, gda_pkg::MON_JUL,
      gda_pkg::MON_AUG, gda_pkg::MON_OCT, gda_pkg::MON_DEC:
        return gda_pkg::DAYS_LONG;
      gda_pkg::MON_APR, gda_pkg::MON_JUN, gda_pkg::MON_SEP, gda_pkg::MON_NOV:
        return gda_pkg::DAYS_SHORT;
      gda_pkg::MON_FEB:
        return leap_year(y) ? gda_pkg::DAYS_FEB_LP : gda_pkg::DAYS_FEB;
      default: return gda_pkg::DAYS_NONE;
    endcase
  endfunction

  // check the start date, then walk forward one day at a time
  function automatic next_date_t advance_date(date_t s, logic [7:0] n);
    next_date_t r;
    date_t      t;
    logic [4:0] len;
    r.ok = 1'b0;
    r.dt = s;
    t = s;
    len = days_in(s.m, s.y);
    if (len == gda_pkg::DAYS_NONE || s.d == 0 || s.d > len) return r;
    for (int k = 0; k < n; k++) begin
      if (t.d == days_in(t.m, t.y)) begin
        t.d = 5'd1;
        if (t.m == gda_pkg::MON_DEC) begin
          t.m = gda_pkg::MON_JAN;
          t.y = t.y + 16'd1;
        end else begin
          t.m = t.m + 4'd1;
        end
      end else begin
        t.d = t.d + 5'd1;
      end
    end
    r.ok = 1'b1;
    r.dt = t;
    return r;
  endfunction

  // mostly well-formed dates near month, year and century ends; some noise
  function automatic date_t random_date();
    date_t      t;
    logic [4:0] len;
    int         pick;
    pick = $urandom_range(99);
    t.d = 5'($urandom_range(31));
    t.m = 4'($urandom_range(15));
    t.y = 16'($urandom_range(65535));
    if (pick >= 12) begin
      t.m = 4'($urandom_range(12, 1));
      case ($urandom_range(4))
        0: t.y = 16'(100 * $urandom_range(655));
        1: t.y = 16'(100 * $urandom_range(655) + $urandom_range(4));
        2: t.y = 16'(16'hFFFF - $urandom_range(3));
        3: t.y = 16'($urandom_range(3));
        default: ;
      endcase
      if ($urandom_range(3) == 0) t.m = gda_pkg::MON_DEC;
      len = days_in(t.m, t.y);
      if (pick < 20) t.d = len + 5'd1;
      else if (pick < 55) t.d = 5'(len - $urandom_range(2));
      else t.d = 5'($urandom_range(len, 1));
    end
    return t;
  endfunction

  function automatic void push_date(logic [4:0] d, logic [3:0] m, logic [15:0] y);
    date_t t;
    t.d = d;
    t.m = m;
    t.y = y;
    start_dates.push_back(t);
  endfunction

  // wait until every date is sent and every result is back
  task automatic drain();
    do @(negedge clk);
    while (start_dates.size() != 0 || in_valid || due_results.size() != 0);
  endtask

  task automatic write_step(logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    step_now  = v;
    @(negedge clk);
  endtask

  // send start dates; predict on each accepted word
  always @(posedge clk) begin : send_dates
    logic  took;
    date_t w;
    took = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        w.d = day;
        w.m = month;
        w.y = year;
        due_results.push_back(advance_date(w, step_now));
        took = 1'b1;
      end
      if (!in_valid || took) begin
        if (start_dates.size() != 0 && (quiet || $urandom_range(99) >= 31)) begin
          w = start_dates.pop_front();
          day      <= w.d;
          month    <= w.m;
          year     <= w.y;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // stall results at random, with one long hold when armed
  always @(posedge clk) begin : stall_results
    if (rx_hold_arm && !hold_taken) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 31);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : check_results
    next_date_t e;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected: %0d %0d/%0d/%0d",
               valid_res, out_day, out_month, out_year);
        fails++;
      end else begin
        e = due_results.pop_front();
        if (valid_res !== e.ok) begin
          $error("valid_res: expected %0d, got %0d", e.ok, valid_res);
          fails++;
        end
        if (out_day !== e.dt.d) begin
          $error("out_day: expected %0d, got %0d", e.dt.d, out_day);
          fails++;
        end
        if (out_month !== e.dt.m) begin
          $error("out_month: expected %0d, got %0d", e.dt.m, out_month);
          fails++;
        end
        if (out_year !== e.dt.y) begin
          $error("out_year: expected %0d, got %0d", e.dt.y, out_year);
          fails++;
        end
        if (e.ok) n_valid++;
        else n_invalid++;
      end
    end
  end

  // give up on a hung run
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > LIMIT) begin
      $display("gregorian_date_advance_tb: FAIL");
      $finish;
    end
  end

  initial begin : run_dates
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed dates at the reset step
    push_date(5'd31, 4'd15, 16'hFFFF);
    push_date(5'd0, 4'd0, 16'd0);
    push_date(5'd1, 4'd13, 16'd2024);
    push_date(5'd15, 4'd14, 16'd1);
    push_date(5'd0, gda_pkg::MON_JAN, 16'd2024);
    push_date(5'd31, gda_pkg::MON_DEC, 16'hFFFF);
    push_date(5'd28, gda_pkg::MON_FEB, 16'd2024);
    push_date(5'd29, gda_pkg::MON_FEB, 16'd2023);
    push_date(5'd29, gda_pkg::MON_FEB, 16'd1900);
    push_date(5'd29, gda_pkg::MON_FEB, 16'd2000);
    push_date(5'd29, gda_pkg::MON_FEB, 16'd0);
    push_date(5'd30, gda_pkg::MON_FEB, 16'd2000);
    push_date(5'd31, gda_pkg::MON_APR, 16'd2021);
    push_date(5'd30, gda_pkg::MON_APR, 16'd2021);
    push_date(5'd31, gda_pkg::MON_JAN, 16'd1999);
    push_date(5'd27, gda_pkg::MON_DEC, 16'd1999);
    push_date(5'd26, gda_pkg::MON_FEB, 16'd2100);
    push_date(5'd1, gda_pkg::MON_JAN, 16'd1);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_step(step_list[p]);
      if (p == HOLD_PHASE) rx_hold_arm = 1'b1;
      quiet = (p == QUIET_PHASE);
      // year wrap and century leap day under each step
      push_date(5'd31, gda_pkg::MON_DEC, 16'hFFFF);
      push_date(5'd29, gda_pkg::MON_FEB, 16'd2000);
      for (int i = 0; i < count_list[p]; i++) start_dates.push_back(random_date());
      drain();
    end
    quiet = 1'b0;

    // let any stray result word show up
    repeat (int'(step_now) + 8) @(posedge clk);
    $display("checked %0d advanced dates and %0d rejected dates", n_valid, n_invalid);
    $display("step settings 5 (reset) then 0 to 255 across %0d phases", N_PHASES);
    if (fails == 0 && due_results.size() == 0) begin
      $display("gregorian_date_advance_tb: PASS");
    end else begin
      $display("gregorian_date_advance_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/gda_pkg.sv
rtl/core/gda_ctrl.sv
rtl/core/gda_dpath.sv
rtl/core/gregorian_date_advance.sv
tb/gregorian_date_advance_tb.sv
